// ===== rtl/lxfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_pkg
// Shared types and constants of the lagged XOR feedback random generator.
// ----------------------------------------------------------------------------
package lxfr_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int TAP_LAG_DEF     = 103;

  localparam int WORD_W   = 16;
  localparam int SEED_W   = 32;
  localparam int SPAN_W   = 17;

  // Column pattern: entries 5k+3 get bit 15-k set, entries 5k+4 get it cleared (k < 16).
  localparam int          PATTERN_STRIDE = 5;
  localparam int          PATTERN_SET    = 3;
  localparam int          PATTERN_CLR    = 4;
  localparam int          COL_COUNT      = 16;
  localparam logic [15:0] TOP_BIT        = 16'h8000;

  typedef enum logic {
    ACT_RESEED = 1'b0,
    ACT_DRAW   = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_DATA
  } st_t;

  typedef struct packed {
    logic load;         // input transfer taken this cycle
    logic sweep_start;  // reseed transfer taken, restart the fill sequence
    logic sweep_en;     // one table entry written by the sweep this cycle
    logic sweep_zero;   // sweep writes zeros (clearing pass after reset)
    logic commit;       // draw result written back and presented
  } ctl_t;

endpackage

// ===== rtl/lxfr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_ram
// Generic synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lxfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/lxfr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_ctrl
// Sequencer: clearing pass, reseed sweep and the draw (read state, then data state).
// ----------------------------------------------------------------------------
module lxfr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           action,
  input  logic           sweep_last,
  input  logic           out_free,
  output logic           s_tready,
  output lxfr_pkg::ctl_t ctl
);

  import lxfr_pkg::*;

  st_t  state;
  st_t  state_next;
  logic accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR, ST_FILL: begin
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_DRAW) ? ST_READ : ST_FILL;
        end
      end
      ST_READ: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (out_free) begin
          if (accept) begin
            state_next = (action == ACT_DRAW) ? ST_READ : ST_FILL;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A new item may be taken in the cycle in which the previous draw commits,
  // since its table reads only start in the following cycle.
  always_comb begin
    s_tready        = 1'b0;
    ctl             = '0;
    case (state)
      ST_CLEAR: begin
        ctl.sweep_en   = 1'b1;
        ctl.sweep_zero = 1'b1;
      end
      ST_FILL: begin
        ctl.sweep_en = 1'b1;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_DATA: begin
        s_tready   = out_free;
        ctl.commit = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    ctl.load        = s_tvalid && s_tready;
    ctl.sweep_start = s_tvalid && s_tready && (action == ACT_RESEED);
  end

endmodule

// ===== rtl/lxfr_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_fill
// Table sweep: seed sequence and column pattern, or zeros after reset.
// ----------------------------------------------------------------------------
module lxfr_fill #(
  parameter int TABLE_DEPTH = lxfr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lxfr_pkg::ctl_t                 ctl,
  input  logic [lxfr_pkg::SEED_W-1:0]    seed,
  output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
  output logic [lxfr_pkg::WORD_W-1:0]    fill_data,
  output logic                           sweep_last
);

  import lxfr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [AW-1:0]     count;
  logic [SEED_W-1:0] x;
  logic [SEED_W-1:0] x_next;
  logic [2:0]        phase;
  logic [4:0]        col;
  logic [WORD_W-1:0] col_bit;
  logic [WORD_W-1:0] word;
  logic              col_live;

  // Multiplying by 65539 is the sum of x, 2x and x shifted up by 16.
  assign x_next = x + {x[SEED_W-2:0], 1'b0} + {x[SEED_W-17:0], 16'h0000};

  assign col_live = (col < 5'(COL_COUNT));
  assign col_bit  = TOP_BIT >> col[3:0];

  always_comb begin
    word = x_next[WORD_W-1:0];
    if (col_live && (phase == 3'(PATTERN_SET))) begin
      word = word | col_bit;
    end else if (col_live && (phase == 3'(PATTERN_CLR))) begin
      word = word & ~col_bit;
    end
  end

  assign fill_addr  = count;
  assign fill_data  = ctl.sweep_zero ? '0 : word;
  assign sweep_last = (count == AW'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      phase <= '0;
      col   <= '0;
    end else if (ctl.sweep_start) begin
      count <= '0;
      phase <= '0;
      col   <= '0;
    end else if (ctl.sweep_en) begin
      count <= sweep_last ? '0 : count + 1'b1;
      if (phase == 3'(PATTERN_STRIDE - 1)) begin
        phase <= '0;
      end else begin
        phase <= phase + 1'b1;
      end
      if (col_live && (phase == 3'(PATTERN_CLR))) begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sweep_start) begin
      x <= seed;
    end else if (ctl.sweep_en) begin
      x <= x_next;
    end
  end

endmodule

// ===== rtl/lxfr_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_draw
// Read position, tap address, XOR write-back word, range scaling and the
// result register.
// ----------------------------------------------------------------------------
module lxfr_draw #(
  parameter int TABLE_DEPTH = lxfr_pkg::TABLE_DEPTH_DEF,
  parameter int TAP_LAG     = lxfr_pkg::TAP_LAG_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lxfr_pkg::ctl_t                 ctl,
  input  logic [lxfr_pkg::WORD_W-1:0]    range_low,
  input  logic [lxfr_pkg::WORD_W-1:0]    range_high,
  input  logic [lxfr_pkg::WORD_W-1:0]    pos_data,
  input  logic [lxfr_pkg::WORD_W-1:0]    tap_data,
  output logic [$clog2(TABLE_DEPTH)-1:0] pos,
  output logic [$clog2(TABLE_DEPTH)-1:0] tap,
  output logic [lxfr_pkg::WORD_W-1:0]    raw,
  output logic                           out_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [2*lxfr_pkg::WORD_W-1:0]  m_tdata
);

  import lxfr_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int LAG_MOD = TAP_LAG % TABLE_DEPTH;

  logic [AW:0]               tap_sum;
  logic [WORD_W-1:0]         low;
  logic signed [SPAN_W-1:0]  span;
  logic signed [2*SPAN_W-2:0] prod;
  logic [WORD_W-1:0]         ranged;
  logic                      m_tvalid_next;

  assign tap_sum = {1'b0, pos} + (AW+1)'(LAG_MOD);
  assign tap     = (tap_sum >= (AW+1)'(TABLE_DEPTH)) ?
                   AW'(tap_sum - (AW+1)'(TABLE_DEPTH)) : tap_sum[AW-1:0];

  assign raw = pos_data ^ tap_data;

  // Bits 30..15 of the product are the low half of its arithmetic shift by 15.
  assign prod   = $signed({1'b0, raw[WORD_W-2:0]}) * span;
  assign ranged = prod[2*WORD_W-2:WORD_W-1] + low;

  assign out_free      = !m_tvalid || m_tready;
  assign m_tvalid_next = ctl.commit || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (ctl.commit) begin
        pos <= (pos == AW'(TABLE_DEPTH - 1)) ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      low  <= range_low;
      span <= $signed({1'b0, range_high}) - $signed({1'b0, range_low});
    end
    if (ctl.commit) begin
      m_tdata <= {ranged, raw};
    end
  end

endmodule

// ===== rtl/lagged_xor_feedback_random_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_xor_feedback_random_core
// Feedback shift register random generator over a table of 16-bit words.
//
//   Channel  Dir  Carries
//   s_*      in   tuser: action; tdata: seed, range_low, range_high
//   m_*      out  tdata: raw_word, ranged_value (one per draw, none per reseed)
//
// A draw reads the position and tap entries from the table RAM, then XORs
// them, writes the word back and loads the result register.
// A reseed sweeps every entry of the RAM, one entry per cycle.
// After reset a clearing pass zeroes every table entry; no transfer is
// taken until it ends.
// A draw whose result register is still full waits in its last cycle.
// ----------------------------------------------------------------------------
module lagged_xor_feedback_random_core #(
  parameter int TABLE_DEPTH = lxfr_pkg::TABLE_DEPTH_DEF,
  parameter int TAP_LAG     = lxfr_pkg::TAP_LAG_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // seed[31:0], range_low[47:32], range_high[63:48]
  input  logic [0:0]  s_tuser,   // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // raw_word[15:0], ranged_value[31:16]
);

  import lxfr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  ctl_t              ctl;
  logic              sweep_last;
  logic              out_free;
  logic [AW-1:0]     fill_addr;
  logic [WORD_W-1:0] fill_data;
  logic [AW-1:0]     pos;
  logic [AW-1:0]     tap;
  logic [WORD_W-1:0] raw;
  logic [WORD_W-1:0] pos_data;
  logic [WORD_W-1:0] tap_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  lxfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .action     (s_tuser[0]),
    .sweep_last (sweep_last),
    .out_free   (out_free),
    .s_tready   (s_tready),
    .ctl        (ctl)
  );

  lxfr_fill #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_fill (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .seed       (s_tdata[31:0]),
    .fill_addr  (fill_addr),
    .fill_data  (fill_data),
    .sweep_last (sweep_last)
  );

  lxfr_draw #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAP_LAG     (TAP_LAG)
  ) u_draw (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .range_low  (s_tdata[47:32]),
    .range_high (s_tdata[63:48]),
    .pos_data   (pos_data),
    .tap_data   (tap_data),
    .pos        (pos),
    .tap        (tap),
    .raw        (raw),
    .out_free   (out_free),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  assign wr_en   = ctl.sweep_en || ctl.commit;
  assign wr_addr = ctl.commit ? pos : fill_addr;
  assign wr_data = ctl.commit ? raw : fill_data;

  lxfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (pos),
    .rd_data_a (pos_data),
    .rd_addr_b (tap),
    .rd_data_b (tap_data)
  );

endmodule

// ===== rtl/lxfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module lxfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // The clearing pass holds off input straight after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during the clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown straight after reset");

  // Every item keeps the block busy for at least the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second input transfer in consecutive cycles");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind lagged_xor_feedback_random_core lxfr_checker u_lxfr_checker (.*);
